// ===== sv/mkp_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and helpers for the md5 key-to-node partition block
// holds the md5 round tables and round functions; no dependencies

package mkp_pkg;

    localparam int KEY_W  = 28;
    localparam int DIGITS = 9;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [31:0] RECIP10 = 32'hcccccccd;
    localparam logic [31:0] LEN_WORD = 32'd72;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] K_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int S_TAB [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    function automatic int shift_amt(int i);
        return S_TAB[((i >> 4) << 2) | (i & 3)];
    endfunction

    function automatic int msg_idx(int i);
        int g;
        if (i < 16) begin
            g = i;
        end else if (i < 32) begin
            g = (5 * i + 1) & 15;
        end else if (i < 48) begin
            g = (3 * i + 5) & 15;
        end else begin
            g = (7 * i) & 15;
        end
        return g;
    endfunction

    function automatic logic [31:0] rotl(logic [31:0] x, int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic logic [31:0] md5_f(int i, logic [31:0] b, logic [31:0] c,
                                          logic [31:0] d);
        logic [31:0] f;
        if (i < 16) begin
            f = (b & c) | (~b & d);
        end else if (i < 32) begin
            f = (d & b) | (~d & c);
        end else if (i < 48) begin
            f = b ^ c ^ d;
        end else begin
            f = c ^ (b | ~d);
        end
        return f;
    endfunction

    // only words 0..2 and the length word are nonzero for a 9-byte message
    function automatic logic [31:0] msg_word(int g, logic [31:0] m0, logic [31:0] m1,
                                             logic [31:0] m2);
        logic [31:0] w;
        case (g)
            0:       w = m0;
            1:       w = m1;
            2:       w = m2;
            14:      w = LEN_WORD;
            default: w = 32'd0;
        endcase
        return w;
    endfunction

endpackage

// ===== sv/mkp_dec.sv =====
`timescale 1ns / 1ps
// signed key to padded decimal text, one digit per pipeline stage
// depends on mkp_pkg

module mkp_dec (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [mkp_pkg::KEY_W-1:0]  i_key,
    output logic                       o_valid,
    output logic [31:0]                o_m0,
    output logic [31:0]                o_m1,
    output logic [31:0]                o_m2
);

    localparam int ND = mkp_pkg::DIGITS;

    logic                          r_v   [ND];
    logic [mkp_pkg::KEY_W-1:0]     r_mag [ND];
    logic [ND-1:0][3:0]            r_dig [ND];
    logic [3:0]                    r_nd  [ND];
    logic                          r_neg [ND];

    logic                          w_neg0;
    logic [mkp_pkg::KEY_W-1:0]     w_mag0;

    assign w_neg0 = i_key[mkp_pkg::KEY_W-1];
    assign w_mag0 = w_neg0 ? (mkp_pkg::KEY_W'(0) - i_key) : i_key;

    for (genvar k = 0; k < ND; k++) begin : g_dig
        logic                      w_v;
        logic [mkp_pkg::KEY_W-1:0] w_mag;
        logic [ND-1:0][3:0]        w_dig;
        logic [3:0]                w_nd;
        logic                      w_neg;
        logic [59:0]               w_prod;
        logic [24:0]               w_q;
        logic [mkp_pkg::KEY_W-1:0] w_q10;
        logic [3:0]                w_d;
        logic                      w_cnt;
        logic [ND-1:0][3:0]        n_dig;

        if (k == 0) begin : g_first
            assign w_v   = i_valid;
            assign w_mag = w_mag0;
            assign w_dig = '0;
            assign w_nd  = 4'd0;
            assign w_neg = w_neg0;
            assign w_cnt = 1'b1;
        end else begin : g_next
            assign w_v   = r_v[k-1];
            assign w_mag = r_mag[k-1];
            assign w_dig = r_dig[k-1];
            assign w_nd  = r_nd[k-1];
            assign w_neg = r_neg[k-1];
            assign w_cnt = (w_mag != '0);
        end

        assign w_prod = 60'(w_mag) * 60'(mkp_pkg::RECIP10);
        assign w_q    = w_prod[59:35];
        assign w_q10  = (mkp_pkg::KEY_W'(w_q) << 3) + (mkp_pkg::KEY_W'(w_q) << 1);
        assign w_d    = 4'(w_mag - w_q10);
        assign n_dig  = w_dig | ((ND*4)'(w_d) << (4 * k));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_mag[k]    <= mkp_pkg::KEY_W'(w_q);
            r_dig[k]    <= n_dig;
            r_nd[k]     <= w_cnt ? (w_nd + 4'd1) : w_nd;
            r_neg[k]    <= w_neg;
        end
    end

    logic [ND-1:0][3:0] w_digs;
    logic [3:0]         w_nd_f;
    logic               w_neg_f;
    logic [ND-1:0][7:0] w_msg;

    assign w_digs  = r_dig[ND-1];
    assign w_nd_f  = r_nd[ND-1];
    assign w_neg_f = r_neg[ND-1];

    always_comb begin
        logic [3:0] j;
        logic [3:0] idx;
        for (int p = 0; p < ND; p++) begin
            w_msg[p] = 8'd0;
            if (w_neg_f && p == 0) begin
                w_msg[p] = mkp_pkg::CH_MINUS;
            end else begin
                j = w_neg_f ? 4'(p - 1) : 4'(p);
                idx = w_nd_f - 4'd1 - j;
                if (j < w_nd_f) begin
                    w_msg[p] = mkp_pkg::CH_ZERO + {4'd0, w_digs[idx]};
                end
            end
        end
    end

    logic        r_ov;
    logic [31:0] r_m0;
    logic [31:0] r_m1;
    logic [31:0] r_m2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[ND-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_m0 <= {w_msg[3], w_msg[2], w_msg[1], w_msg[0]};
        r_m1 <= {w_msg[7], w_msg[6], w_msg[5], w_msg[4]};
        r_m2 <= {16'd0, mkp_pkg::PAD_BYTE, w_msg[8]};
    end

    assign o_valid = r_ov;
    assign o_m0    = r_m0;
    assign o_m1    = r_m1;
    assign o_m2    = r_m2;

endmodule

// ===== sv/mkp_md5.sv =====
`timescale 1ns / 1ps
// md5 compression of one padded block, one round per pipeline stage
// depends on mkp_pkg; returns digest bytes 12..15 big-endian

module mkp_md5 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_m0,
    input  logic [31:0] i_m1,
    input  logic [31:0] i_m2,
    output logic        o_valid,
    output logic [31:0] o_hash
);

    logic        r_v  [64];
    logic [31:0] r_a  [64];
    logic [31:0] r_b  [64];
    logic [31:0] r_c  [64];
    logic [31:0] r_d  [64];
    logic [31:0] r_m0 [64];
    logic [31:0] r_m1 [64];
    logic [31:0] r_m2 [64];

    for (genvar i = 0; i < 64; i++) begin : g_rnd
        logic        w_v;
        logic [31:0] w_a, w_b, w_c, w_d, w_m0, w_m1, w_m2, w_f;

        if (i == 0) begin : g_first
            assign w_v  = i_valid;
            assign w_a  = mkp_pkg::IV_A;
            assign w_b  = mkp_pkg::IV_B;
            assign w_c  = mkp_pkg::IV_C;
            assign w_d  = mkp_pkg::IV_D;
            assign w_m0 = i_m0;
            assign w_m1 = i_m1;
            assign w_m2 = i_m2;
        end else begin : g_next
            assign w_v  = r_v[i-1];
            assign w_a  = r_a[i-1];
            assign w_b  = r_b[i-1];
            assign w_c  = r_c[i-1];
            assign w_d  = r_d[i-1];
            assign w_m0 = r_m0[i-1];
            assign w_m1 = r_m1[i-1];
            assign w_m2 = r_m2[i-1];
        end

        assign w_f = mkp_pkg::md5_f(i, w_b, w_c, w_d) + w_a + mkp_pkg::K_TAB[i]
                   + mkp_pkg::msg_word(mkp_pkg::msg_idx(i), w_m0, w_m1, w_m2);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else begin
                r_v[i] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_a[i]  <= w_d;
            r_d[i]  <= w_c;
            r_c[i]  <= w_b;
            r_b[i]  <= w_b + mkp_pkg::rotl(w_f, mkp_pkg::shift_amt(i));
            r_m0[i] <= w_m0;
            r_m1[i] <= w_m1;
            r_m2[i] <= w_m2;
        end
    end

    logic        r_hv;
    logic [31:0] r_hash;
    logic [31:0] w_dsum;

    assign w_dsum = r_d[63] + mkp_pkg::IV_D;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
        end else begin
            r_hv <= r_v[63];
        end
    end

    always_ff @(posedge i_clk) begin
        r_hash <= {w_dsum[7:0], w_dsum[15:8], w_dsum[23:16], w_dsum[31:24]};
    end

    assign o_valid = r_hv;
    assign o_hash  = r_hash;

endmodule

// ===== sv/mkp_div.sv =====
`timescale 1ns / 1ps
// pipelined restoring divider, hash by node range, one quotient bit per stage
// no package dependencies

module mkp_div #(
    parameter int QW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [31:0]   i_hash,
    input  logic [31:0]   i_range,
    output logic          o_valid,
    output logic [31:0]   o_hash,
    output logic [QW-1:0] o_quot
);

    logic          r_v    [QW];
    logic [31:0]   r_rem  [QW];
    logic [31:0]   r_hash [QW];
    logic [QW-1:0] r_q    [QW];

    for (genvar i = 0; i < QW; i++) begin : g_bit
        logic          w_v;
        logic [31:0]   w_rem, w_hash;
        logic [QW-1:0] w_q;
        logic [31+QW:0] w_cand;
        logic          w_ge;
        logic [QW-1:0] n_q;

        if (i == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_rem  = i_hash;
            assign w_hash = i_hash;
            assign w_q    = '0;
        end else begin : g_next
            assign w_v    = r_v[i-1];
            assign w_rem  = r_rem[i-1];
            assign w_hash = r_hash[i-1];
            assign w_q    = r_q[i-1];
        end

        assign w_cand = (32+QW)'(i_range) << (QW - 1 - i);
        assign w_ge   = ((32+QW)'(w_rem) >= w_cand);
        assign n_q    = w_q | (QW'(w_ge) << (QW - 1 - i));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else begin
                r_v[i] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[i]  <= w_ge ? (w_rem - w_cand[31:0]) : w_rem;
            r_hash[i] <= w_hash;
            r_q[i]    <= n_q;
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_hash  = r_hash[QW-1];
    assign o_quot  = r_q[QW-1];

endmodule

// ===== sv/md5_key_to_node_partition.sv =====
`timescale 1ns / 1ps
// md5 hash-range partitioning: key -> decimal text -> md5 -> node index
// the pipeline runs through nine digit stages, one format stage, 64 md5 rounds,
// a digest stage, the divider and the output
// throughput one key per cycle; busy never rises and the receiver cannot stall
// synchronous active-low reset clears the pipeline valid bits and sets node_count to min(MAX_NODES, 4)

module md5_key_to_node_partition #(
    parameter int MAX_NODES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [27:0] i_user_key,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_node_count,
    output logic        o_valid,
    output logic [3:0]  o_node_index,
    output logic [4:0]  o_machine_id,
    output logic [31:0] o_hash_value
);

    localparam int QW      = $clog2(MAX_NODES + 1);
    localparam int IW      = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int RESET_N = (MAX_NODES < 4) ? MAX_NODES : 4;
    localparam logic [31:0] RESET_RANGE = 32'(64'hffffffff / RESET_N);
    localparam int LAT     = 76 + QW;

    logic [31:0] w_range_tab [MAX_NODES];
    for (genvar k = 0; k < MAX_NODES; k++) begin : g_tab
        localparam logic [31:0] RANGE_K = 32'(64'hffffffff / (k + 1));
        assign w_range_tab[k] = RANGE_K;
    end

    logic [31:0]   w_cfg32;
    logic [31:0]   w_nclamp;
    logic [QW-1:0] r_n;
    logic [31:0]   r_range;

    assign w_cfg32  = 32'(i_cfg_node_count);
    assign w_nclamp = (w_cfg32 == 32'd0) ? 32'd1 :
                      (w_cfg32 > 32'(MAX_NODES)) ? 32'(MAX_NODES) : w_cfg32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n     <= QW'(RESET_N);
            r_range <= RESET_RANGE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_n     <= QW'(w_nclamp);
            r_range <= w_range_tab[IW'(w_nclamp - 32'd1)];
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    logic        w_dv;
    logic [31:0] w_m0, w_m1, w_m2;
    logic        w_hv;
    logic [31:0] w_hash;
    logic        w_qv;
    logic [31:0] w_qhash;
    logic [QW-1:0] w_quot;

    mkp_dec u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_key   (i_user_key),
        .o_valid (w_dv),
        .o_m0    (w_m0),
        .o_m1    (w_m1),
        .o_m2    (w_m2)
    );

    mkp_md5 u_md5 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dv),
        .i_m0    (w_m0),
        .i_m1    (w_m1),
        .i_m2    (w_m2),
        .o_valid (w_hv),
        .o_hash  (w_hash)
    );

    mkp_div #(.QW(QW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_hv),
        .i_hash  (w_hash),
        .i_range (r_range),
        .o_valid (w_qv),
        .o_hash  (w_qhash),
        .o_quot  (w_quot)
    );

    logic [QW-1:0] w_idx;
    logic          r_ov;
    logic [3:0]    r_idx;
    logic [4:0]    r_mid;
    logic [31:0]   r_hash;

    assign w_idx = (w_quot >= r_n) ? '0 : w_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= w_qv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= 4'(w_idx);
        r_mid  <= 5'(w_idx) + 5'd1;
        r_hash <= w_qhash;
    end

    assign o_valid      = r_ov;
    assign o_node_index = r_idx;
    assign o_machine_id = r_mid;
    assign o_hash_value = r_hash;

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_valid)
        else $error("accepted key produced no result at the expected latency");

    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result strobe without a matching accepted key");

    a_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_machine_id == 5'(o_node_index) + 5'd1))
        else $error("machine id does not follow node index");

    a_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $stable(r_n) |-> (32'(o_node_index) < 32'(r_n)))
        else $error("node index outside the configured node count");

endmodule

// ===== tb/tb_md5_key_to_node_partition.sv =====
`timescale 1ns / 1ps
// testbench for md5_key_to_node_partition: directed key table, then random keys per node count
// an independent md5 predictor checks hashes and untyped ids; depends on the block's rtl only

module tb_md5_key_to_node_partition;

    typedef struct packed {
        logic [3:0]  node_index;
        logic [4:0]  machine_id;
        logic [31:0] hash_value;
    } t_partition;

    typedef struct {
        logic [4:0]  nodes;
        logic [27:0] key;
        bit          typed;
        logic [3:0]  node_index;
        logic [4:0]  machine_id;
    } t_key_row;

    localparam int LATENCY = 81;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int ROUND_S [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [27:0] i_user_key = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_node_count = '0;
    logic        o_valid;
    logic [3:0]  o_node_index;
    logic [4:0]  o_machine_id;
    logic [31:0] o_hash_value;

    t_partition  pending_partitions[$];
    logic [4:0]  node_count_shadow = 5'd4;
    int          errors = 0;

    md5_key_to_node_partition dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_user_key      (i_user_key),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_node_count(i_cfg_node_count),
        .o_valid         (o_valid),
        .o_node_index    (o_node_index),
        .o_machine_id    (o_machine_id),
        .o_hash_value    (o_hash_value)
    );

    always #10 i_clk = ~i_clk;

    // decimal text of the key, zero padded to nine bytes, md5 tail word byte swapped
    function automatic logic [31:0] key_hash(logic [27:0] key);
        logic [7:0]  blk [64];
        logic [7:0]  digit [12];
        logic [31:0] m [16];
        logic [31:0] mag, a, b, c, d, f, t;
        int          nd, pos, g, r;
        nd = 0;
        pos = 0;
        mag = key[27] ? (32'h1000_0000 - {4'd0, key}) : {4'd0, key};
        for (int i = 0; i < 64; i++) blk[i] = 8'h00;
        do begin
            digit[nd] = 8'h30 + 8'(mag % 10);
            nd++;
            mag = mag / 10;
        end while (mag != 0 && nd < 12);
        if (key[27]) begin
            blk[pos] = 8'h2d;
            pos++;
        end
        while (nd > 0 && pos < 9) begin
            nd--;
            blk[pos] = digit[nd];
            pos++;
        end
        blk[9] = 8'h80;
        blk[56] = 8'd72;
        for (int i = 0; i < 16; i++)
            m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
        a = 32'h67452301;
        b = 32'hefcdab89;
        c = 32'h98badcfe;
        d = 32'h10325476;
        for (int i = 0; i < 64; i++) begin
            if (i < 16) begin
                f = (b & c) | (~b & d);
                g = i;
            end else if (i < 32) begin
                f = (d & b) | (~d & c);
                g = (5 * i + 1) % 16;
            end else if (i < 48) begin
                f = b ^ c ^ d;
                g = (3 * i + 5) % 16;
            end else begin
                f = c ^ (b | ~d);
                g = (7 * i) % 16;
            end
            f = f + a + ROUND_K[i] + m[g];
            r = ROUND_S[(i / 16) * 4 + i % 4];
            a = d;
            d = c;
            c = b;
            b = b + ((f << r) | (f >> (32 - r)));
        end
        t = d + 32'h10325476;
        return {t[7:0], t[15:8], t[23:16], t[31:24]};
    endfunction

    function automatic t_partition partition_of(logic [27:0] key, logic [4:0] nodes);
        t_partition p;
        logic [31:0] n, slice, q;
        n = (nodes == 0) ? 32'd1 : (nodes > 16) ? 32'd16 : {27'd0, nodes};
        p.hash_value = key_hash(key);
        slice = 32'hffff_ffff / n;
        q = p.hash_value / slice;
        if (q >= n) q = 0;
        p.node_index = q[3:0];
        p.machine_id = 5'(q + 1);
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_partition exp_p;
        if (i_rst_n && o_valid) begin
            if (pending_partitions.size() == 0) begin
                $display("%0t: unexpected result idx=%0d mid=%0d hash=%h",
                         $time, o_node_index, o_machine_id, o_hash_value);
                errors++;
            end else begin
                exp_p = pending_partitions.pop_front();
                if (o_node_index !== exp_p.node_index) begin
                    $display("%0t: node_index expected %0d actual %0d",
                             $time, exp_p.node_index, o_node_index);
                    errors++;
                end
                if (o_machine_id !== exp_p.machine_id) begin
                    $display("%0t: machine_id expected %0d actual %0d",
                             $time, exp_p.machine_id, o_machine_id);
                    errors++;
                end
                if (o_hash_value !== exp_p.hash_value) begin
                    $display("%0t: hash_value expected %h actual %h",
                             $time, exp_p.hash_value, o_hash_value);
                    errors++;
                end
            end
        end
    end

    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain_and_set_nodes(logic [4:0] nodes);
        while (pending_partitions.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_node_count <= nodes;
        do @(posedge i_clk); while (!o_cfg_ready);
        node_count_shadow = nodes;
        i_cfg_valid <= 1'b0;
        if ($urandom_range(0, 1)) i_cfg_node_count <= 5'($urandom);
    endtask

    task automatic send_key(logic [27:0] key, bit typed, logic [3:0] idx, logic [4:0] mid,
                            bit gaps);
        t_partition p;
        start <= 1'b1;
        i_user_key <= key;
        do @(posedge i_clk); while (busy);
        p = partition_of(key, node_count_shadow);
        if (typed) begin
            p.node_index = idx;
            p.machine_id = mid;
        end
        pending_partitions.push_back(p);
        if (gaps) idle_gap();
    endtask

    function automatic logic [27:0] random_key();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return 28'($urandom_range(0, 99999999));
        if (pick < 7) return 28'(-$signed($urandom_range(1, 9999999)));
        if (pick < 8) return 28'($urandom_range(0, 999) - 500);
        return 28'($urandom);
    endfunction

    t_key_row key_rows [23] = '{
        '{5'd4,  28'd0,         0, 4'd0, 5'd0},
        '{5'd4,  28'd1,         0, 4'd0, 5'd0},
        '{5'd4,  28'hfffffff,   0, 4'd0, 5'd0},
        '{5'd4,  28'd9,         0, 4'd0, 5'd0},
        '{5'd4,  28'd10,        0, 4'd0, 5'd0},
        '{5'd4,  28'd99999999,  0, 4'd0, 5'd0},
        '{5'd4,  28'hf676981,   0, 4'd0, 5'd0},
        '{5'd4,  28'd12345678,  0, 4'd0, 5'd0},
        '{5'd1,  28'd0,         1, 4'd0, 5'd1},
        '{5'd1,  28'd99999999,  1, 4'd0, 5'd1},
        '{5'd1,  28'hf676981,   1, 4'd0, 5'd1},
        '{5'd0,  28'd42,        1, 4'd0, 5'd1},
        '{5'd0,  28'hfffffff,   1, 4'd0, 5'd1},
        '{5'd16, 28'd100000000, 0, 4'd0, 5'd0},
        '{5'd16, 28'h7ffffff,   0, 4'd0, 5'd0},
        '{5'd16, 28'h8000000,   0, 4'd0, 5'd0},
        '{5'd16, 28'h5555555,   0, 4'd0, 5'd0},
        '{5'd16, 28'haaaaaaa,   0, 4'd0, 5'd0},
        '{5'd31, 28'd7,         0, 4'd0, 5'd0},
        '{5'd31, 28'h8000001,   0, 4'd0, 5'd0},
        '{5'd17, 28'd555,       0, 4'd0, 5'd0},
        '{5'd3,  28'd123456789, 0, 4'd0, 5'd0},
        '{5'd3,  28'hff0bdc1,   0, 4'd0, 5'd0}
    };

    logic [4:0] phase_nodes [9] = '{5'd4, 5'd1, 5'd16, 5'd0, 5'd31, 5'd7, 5'd2, 5'd13, 5'd17};

    initial begin
        bit gaps;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (key_rows[i]) begin
            if (key_rows[i].nodes != node_count_shadow) begin
                start <= 1'b0;
                drain_and_set_nodes(key_rows[i].nodes);
            end
            send_key(key_rows[i].key, key_rows[i].typed, key_rows[i].node_index,
                     key_rows[i].machine_id, 1'b1);
        end
        foreach (phase_nodes[ph]) begin
            start <= 1'b0;
            drain_and_set_nodes(phase_nodes[ph] == 5'd7 ? 5'($urandom_range(1, 16))
                                                        : phase_nodes[ph]);
            gaps = (ph % 3) != 1;
            repeat (155) send_key(random_key(), 1'b0, 4'd0, 5'd0, gaps);
        end
        start <= 1'b0;
        while (pending_partitions.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
